// ===== rtl/core/http_header_length_framer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// HTTP header length framer assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LENGTH_FRAMER_UNIT_ASSERT_SVH
`define HTTP_HEADER_LENGTH_FRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define HHLF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hhlf assertion failed");

// Antecedent implies consequent in the same cycle.
`define HHLF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhlf implication failed");

// Antecedent implies consequent in the next cycle.
`define HHLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhlf next-cycle check failed");

`else

`define HHLF_ASSERT(label, clk, rst_n, prop)
`define HHLF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HHLF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/hhlf_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP header length framer package
// Shared types, constants and the header keyword table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hhlf_pkg;

  localparam int unsigned LengthBitsDefault = 31;
  localparam int unsigned LimitBits         = 12;
  localparam logic [LimitBits-1:0] HeaderLimitReset = 12'd2048;
  localparam logic [4:0] KeyLen = 5'd16;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhBody   = 2'd1,
    PhDone   = 2'd2,
    PhError  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    NumIdle   = 3'd0,
    NumSpace  = 3'd1,
    NumSign   = 3'd2,
    NumDigits = 3'd3,
    NumDone   = 3'd4
  } num_stage_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrLength  = 2'd1,
    ErrTooLong = 2'd2
  } err_kind_e;

  // "Content-Length: "
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3a;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/http_header_length_framer_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP header length framer
// Finds the header end and Content-Length of one request, then frames body.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o | mode_i, data_byte_i
//  out     | out_valid_o/out_ready_i | phase_o, is_body_o, is_last_o,
//          |                         | body_length_o, error_kind_o
//  cfg     | cfg_we_i                | cfg_wdata_i (header limit)
//
// One item per cycle while the output is not stalled; an accepted item goes
// through the input register, then one pass of byte logic into the result reg.
// The per-byte state update is a single step: keyword match, CR LF CR LF
// tracker, decimal shift-add with saturation, body counter compare.
// Reset clears all request state and loads the header limit with 2048.
// A stalled output holds the result register and the input register; the
// input side keeps taking items as long as the input register can drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "http_header_length_framer_unit_assert.svh"

module http_header_length_framer_unit
  import hhlf_pkg::*;
#(
  parameter int unsigned LengthBits = LengthBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [LimitBits-1:0]  cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  mode_i,
  input  wire logic [7:0]            data_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 phase_o,
  output logic                       is_body_o,
  output logic                       is_last_o,
  output logic [LengthBits-1:0]      body_length_o,
  output logic [1:0]                 error_kind_o
);

  localparam int unsigned ProdBits = LengthBits + 4;
  localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};
  localparam logic [LimitBits-1:0]  CountMax = {LimitBits{1'b1}};

  // input register
  logic       in_valid_q;
  logic       in_mode_q;
  logic [7:0] in_byte_q;
  logic       advance;

  // request state
  logic [LimitBits-1:0]  limit_q;
  phase_e                phase_q, phase_d;
  logic [LimitBits-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [1:0]            sep_q, sep_d;
  logic [4:0]            kw_q, kw_d;
  num_stage_e            num_q, num_d;
  logic                  neg_q, neg_d;
  logic                  nul_q, nul_d;
  logic [LengthBits-1:0] acc_q, acc_d;
  logic [LengthBits-1:0] body_cnt_q, body_cnt_d;
  err_kind_e             err_q, err_d;

  // result register
  logic                  out_valid_q;
  phase_e                res_phase_q;
  logic                  res_body_q, res_last_q;
  logic [LengthBits-1:0] res_len_q;
  err_kind_e             res_err_q;
  logic                  is_body_d, is_last_d;

  // per-byte helpers
  logic                  is_digit;
  logic                  take_digit;
  logic                  sep_done;
  logic                  have_num;
  logic [ProdBits-1:0]   acc_ext, prod;
  logic [4:0]            kw_next;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_mode_q <= mode_i;
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HeaderLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign is_digit = (in_byte_q >= ChZero) && (in_byte_q <= ChNine);
  assign acc_ext  = {4'd0, acc_q};
  assign prod     = (acc_ext << 3) + (acc_ext << 1)
                  + {{(ProdBits-4){1'b0}}, in_byte_q[3:0]};

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    sep_d      = sep_q;
    kw_d       = kw_q;
    num_d      = num_q;
    neg_d      = neg_q;
    nul_d      = nul_q;
    acc_d      = acc_q;
    body_cnt_d = body_cnt_q;
    err_d      = err_q;
    is_body_d  = 1'b0;
    is_last_d  = 1'b0;
    take_digit = 1'b0;
    sep_done   = 1'b0;
    have_num   = 1'b0;
    kw_next    = kw_q;

    if (in_mode_q) begin
      phase_d    = PhHeader;
      hdr_cnt_d  = '0;
      sep_d      = '0;
      kw_d       = '0;
      num_d      = NumIdle;
      neg_d      = 1'b0;
      nul_d      = 1'b0;
      acc_d      = '0;
      body_cnt_d = '0;
      err_d      = ErrNone;
    end else begin
      unique case (phase_q)
        PhHeader: begin
          if (hdr_cnt_q != CountMax) begin
            hdr_cnt_d = hdr_cnt_q + 1'b1;
          end

          // number reader sees the byte before the keyword matcher
          unique case (num_q) inside
            NumSpace: begin
              if (is_space(in_byte_q)) begin
                num_d = NumSpace;
              end else if (in_byte_q == ChPlus || in_byte_q == ChMinus) begin
                neg_d = (in_byte_q == ChMinus);
                num_d = NumSign;
              end else begin
                take_digit = 1'b1;
              end
            end
            NumSign, NumDigits: take_digit = 1'b1;
            default: ;
          endcase
          if (take_digit) begin
            if (!is_digit) begin
              num_d = NumDone;
            end else begin
              acc_d = (prod > {4'd0, LenMax}) ? LenMax : prod[LengthBits-1:0];
              num_d = NumDigits;
            end
          end

          // keyword matcher; a NUL freezes it for the rest of the header
          if (in_byte_q == ChNul) begin
            nul_d = 1'b1;
          end else if (!nul_q && (kw_q < KeyLen)) begin
            if (in_byte_q == key_char(kw_q[3:0])) begin
              kw_next = kw_q + 1'b1;
            end else begin
              kw_next = (in_byte_q == key_char(4'd0)) ? 5'd1 : 5'd0;
            end
            kw_d = kw_next;
            if (kw_next >= KeyLen) begin
              num_d = NumSpace;
            end
          end

          // CR LF CR LF tracker
          if (in_byte_q == (sep_q[0] ? ChLf : ChCr)) begin
            if (sep_q == 2'd3) begin
              sep_d    = 2'd0;
              sep_done = 1'b1;
            end else begin
              sep_d = sep_q + 1'b1;
            end
          end else begin
            sep_d = (in_byte_q == ChCr) ? 2'd1 : 2'd0;
          end

          have_num = (num_d == NumDigits) || (num_d == NumDone);
          if (sep_done) begin
            if (!have_num || (acc_d == '0) || neg_d) begin
              phase_d = PhError;
              err_d   = ErrLength;
            end else begin
              phase_d    = PhBody;
              body_cnt_d = '0;
            end
          end else if (hdr_cnt_d >= limit_q) begin
            phase_d = PhError;
            err_d   = ErrTooLong;
          end
        end
        PhBody: begin
          is_body_d = 1'b1;
          if (body_cnt_q != LenMax) begin
            body_cnt_d = body_cnt_q + 1'b1;
          end
          if (body_cnt_d >= acc_q) begin
            is_last_d = 1'b1;
            phase_d   = PhDone;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      hdr_cnt_q  <= '0;
      sep_q      <= '0;
      kw_q       <= '0;
      num_q      <= NumIdle;
      neg_q      <= 1'b0;
      nul_q      <= 1'b0;
      acc_q      <= '0;
      body_cnt_q <= '0;
      err_q      <= ErrNone;
    end else if (advance) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      sep_q      <= sep_d;
      kw_q       <= kw_d;
      num_q      <= num_d;
      neg_q      <= neg_d;
      nul_q      <= nul_d;
      acc_q      <= acc_d;
      body_cnt_q <= body_cnt_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_phase_q <= phase_d;
      res_body_q  <= is_body_d;
      res_last_q  <= is_last_d;
      res_len_q   <= (phase_d == PhBody || phase_d == PhDone) ? acc_d : '0;
      res_err_q   <= (phase_d == PhError) ? err_d : ErrNone;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign phase_o       = res_phase_q;
  assign is_body_o     = res_body_q;
  assign is_last_o     = res_last_q;
  assign body_length_o = res_len_q;
  assign error_kind_o  = res_err_q;

  `HHLF_ASSERT_IMPLY(a_last_in_done, clk_i, rst_ni, out_valid_q && res_last_q,
                     res_body_q && (res_phase_q == PhDone))
  `HHLF_ASSERT_IMPLY(a_err_only_in_error, clk_i, rst_ni,
                     out_valid_q && (res_phase_q != PhError), res_err_q == ErrNone)
  `HHLF_ASSERT_IMPLY(a_body_has_length, clk_i, rst_ni, phase_q == PhBody,
                     (acc_q != '0) && !neg_q && (err_q == ErrNone))
  `HHLF_ASSERT_NEXT(a_stall_holds_input, clk_i, rst_ni, in_valid_q && !advance,
                    in_valid_q && $stable(in_byte_q) && $stable(in_mode_q))
  `HHLF_ASSERT(a_body_count_bound, clk_i, rst_ni,
               (phase_q != PhBody) || (body_cnt_q < acc_q))

endmodule

`default_nettype wire

// ===== bench/tb_http_header_length_framer_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP header length framer testbench
// Feeds request byte streams through the framer under random idle and stall
// patterns, predicts each result in step with the block and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_http_header_length_framer_unit;
  import hhlf_pkg::*;

  localparam int unsigned LenBits = LengthBitsDefault;
  localparam logic [LenBits-1:0] LenMax = '1;
  localparam logic [127:0] KeyBits = "Content-Length: ";
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic [1:0]         phase;
    logic               is_body;
    logic               is_last;
    logic [LenBits-1:0] body_length;
    logic [1:0]         error_kind;
  } frame_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [LimitBits-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_mode = 1'b0;
  logic [7:0]           in_byte = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [1:0]           phase_out;
  logic                 is_body_out;
  logic                 is_last_out;
  logic [LenBits-1:0]   body_length_out;
  logic [1:0]           error_kind_out;

  // framer state as the block should hold it
  phase_e               ph_m;
  logic [11:0]          hdr_cnt_m;
  logic [1:0]           sep_prog_m;
  logic [4:0]           key_prog_m;
  num_stage_e           num_st_m;
  logic                 neg_m;
  logic                 nul_m;
  logic [LenBits-1:0]   len_acc_m;
  logic [LenBits-1:0]   body_cnt_m;
  err_kind_e            err_m;
  logic [LimitBits-1:0] limit_m;

  frame_t      frame_fifo[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_requests = 0;
  int unsigned n_done = 0;
  int unsigned n_len_err = 0;
  int unsigned n_long_err = 0;

  http_header_length_framer_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (in_mode),
    .data_byte_i  (in_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .phase_o      (phase_out),
    .is_body_o    (is_body_out),
    .is_last_o    (is_last_out),
    .body_length_o(body_length_out),
    .error_kind_o (error_kind_out)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] key_at(input int unsigned idx);
    return KeyBits[8*(15-idx) +: 8];
  endfunction

  function automatic logic blank_byte(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic void clear_request();
    ph_m = PhHeader;
    hdr_cnt_m = '0;
    sep_prog_m = '0;
    key_prog_m = '0;
    num_st_m = NumIdle;
    neg_m = 1'b0;
    nul_m = 1'b0;
    len_acc_m = '0;
    body_cnt_m = '0;
    err_m = ErrNone;
  endfunction

  // Advance the framer by one item and return the result it produces.
  function automatic frame_t parse_byte(input logic m, input logic [7:0] b);
    frame_t r;
    logic sign_taken;
    logic sep_hit;
    logic have_len;
    logic [7:0] want;
    longint unsigned d;
    r = '0;
    sign_taken = 1'b0;
    sep_hit = 1'b0;
    d = longint'(b[3:0]);
    if (m) begin
      clear_request();
    end else if (ph_m == PhHeader) begin
      if (hdr_cnt_m != 12'hfff) hdr_cnt_m++;
      // number reading sees the byte before the keyword matcher does
      if (num_st_m == NumSpace && !blank_byte(b)) begin
        if (b == ChPlus || b == ChMinus) begin
          neg_m = (b == ChMinus);
          sign_taken = 1'b1;
        end
        num_st_m = NumSign;
      end
      if (!sign_taken && (num_st_m == NumSign || num_st_m == NumDigits)) begin
        if (b < ChZero || b > ChNine) begin
          num_st_m = NumDone;
        end else begin
          if (longint'(len_acc_m) > (longint'(LenMax) - d) / 10)
            len_acc_m = LenMax;
          else
            len_acc_m = LenBits'(longint'(len_acc_m) * 10 + d);
          num_st_m = NumDigits;
        end
      end
      if (b == ChNul) begin
        nul_m = 1'b1;
      end else if (!nul_m && key_prog_m < KeyLen) begin
        if (b == key_at(key_prog_m[3:0])) key_prog_m++;
        else key_prog_m = (b == key_at(0)) ? 5'd1 : 5'd0;
        if (key_prog_m >= KeyLen) num_st_m = NumSpace;
      end
      want = sep_prog_m[0] ? ChLf : ChCr;
      if (b == want) begin
        if (sep_prog_m == 2'd3) begin
          sep_prog_m = 2'd0;
          sep_hit = 1'b1;
        end else begin
          sep_prog_m++;
        end
      end else begin
        sep_prog_m = (b == ChCr) ? 2'd1 : 2'd0;
      end
      if (sep_hit) begin
        have_len = (num_st_m == NumDigits || num_st_m == NumDone);
        if (!have_len || len_acc_m == '0 || neg_m) begin
          ph_m = PhError;
          err_m = ErrLength;
          n_len_err++;
        end else begin
          ph_m = PhBody;
          body_cnt_m = '0;
        end
      end else if (hdr_cnt_m >= limit_m) begin
        ph_m = PhError;
        err_m = ErrTooLong;
        n_long_err++;
      end
    end else if (ph_m == PhBody) begin
      r.is_body = 1'b1;
      if (body_cnt_m != LenMax) body_cnt_m++;
      if (body_cnt_m >= len_acc_m) begin
        r.is_last = 1'b1;
        ph_m = PhDone;
      end
    end
    r.phase = ph_m;
    r.body_length = (ph_m == PhBody || ph_m == PhDone) ? len_acc_m : '0;
    r.error_kind = (ph_m == PhError) ? err_m : ErrNone;
    return r;
  endfunction

  task automatic check_frame();
    frame_t want;
    frame_t got;
    got = '{phase_out, is_body_out, is_last_out, body_length_out, error_kind_out};
    n_results++;
    if (frame_fifo.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("[%0t] unexpected result: phase %0d body %0b last %0b len %0d err %0d",
                 $realtime, got.phase, got.is_body, got.is_last, got.body_length,
                 got.error_kind);
    end else begin
      want = frame_fifo.pop_front();
      if (got.is_last) n_done++;
      if (got.phase !== want.phase || got.is_body !== want.is_body ||
          got.is_last !== want.is_last || got.body_length !== want.body_length ||
          got.error_kind !== want.error_kind) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("[%0t] result %0d: want ph %0d bd %0b ls %0b len %0d err %0d, got ph %0d bd %0b ls %0b len %0d err %0d",
                   $realtime, n_results, want.phase, want.is_body, want.is_last,
                   want.body_length, want.error_kind, got.phase, got.is_body,
                   got.is_last, got.body_length, got.error_kind);
      end
    end
  endtask

  // Track accepted items and configuration writes, then check results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) limit_m = cfg_wdata;
      if (in_valid && in_ready) begin
        frame_fifo.push_back(parse_byte(in_mode, in_byte));
        n_items++;
      end
      if (out_valid && out_ready) check_frame();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               frame_fifo.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: long hold-off first, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic m, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= m;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_item(1'b0, s[k]);
  endtask

  task automatic send_crlf();
    send_item(1'b0, ChCr);
    send_item(1'b0, ChLf);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_fifo.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LimitBits-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned s, input int unsigned r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  // One request with random content: mostly well-formed, some broken.
  task automatic run_request();
    logic [7:0] req[$];
    string num_txt;
    int unsigned sel;
    int unsigned val;
    int unsigned n;
    int unsigned i;
    bit sat;
    bit ended;
    sel = $urandom_range(99);
    val = 0;
    sat = 1'b0;
    repeat ($urandom_range(0, 10)) req.push_back(8'($urandom_range(8'h21, 8'h7e)));
    req.push_back(ChCr);
    req.push_back(ChLf);
    if (sel < 8) begin
      // keyword cut short, matching has to start over
      n = $urandom_range(1, 15);
      for (i = 0; i < n; i++) req.push_back(key_at(i));
      req.push_back(8'h78);
    end
    if (sel < 85) begin
      if ($urandom_range(4) == 0) req.push_back(key_at(0));
      for (i = 0; i < 16; i++) req.push_back(key_at(i));
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(3))
          0:       req.push_back(ChSpace);
          1:       req.push_back(ChTab);
          2:       req.push_back(8'h0b);
          default: req.push_back(8'h0c);
        endcase
      end
      case ($urandom_range(9))
        0:       req.push_back(ChMinus);
        1:       req.push_back(ChPlus);
        default: ;
      endcase
      if ($urandom_range(19) == 0) begin
        sat = 1'b1;
        repeat ($urandom_range(10, 12)) req.push_back(8'(ChZero + $urandom_range(9)));
      end else begin
        val = $urandom_range(0, 30);
        if ($urandom_range(4) == 0) req.push_back(ChZero);
        num_txt = $sformatf("%0d", val);
        for (i = 0; i < num_txt.len(); i++) req.push_back(num_txt[i]);
      end
      case ($urandom_range(5))
        0:       req.push_back(ChNul);
        1:       req.push_back(8'h41);
        default: ;
      endcase
      req.push_back(ChCr);
      req.push_back(ChLf);
    end else if (sel < 93) begin
      repeat ($urandom_range(1, 8)) req.push_back(8'($urandom_range(255)));
      req.push_back(ChCr);
      req.push_back(ChLf);
    end else begin
      // zero byte hides the keyword that follows
      req.push_back(ChNul);
      for (i = 0; i < 16; i++) req.push_back(key_at(i));
      req.push_back(8'h35);
      req.push_back(ChCr);
      req.push_back(ChLf);
    end
    ended = ($urandom_range(9) != 0);
    if (ended) begin
      req.push_back(ChCr);
      req.push_back(ChLf);
      n = (sat ? 5 : val) + $urandom_range(0, 3);
    end else begin
      n = $urandom_range(0, 3);
    end
    repeat (n) req.push_back(8'($urandom_range(255)));
    send_item(1'b1, 8'($urandom_range(255)));
    for (i = 0; i < req.size(); i++) send_item(1'b0, req[i]);
    n_requests++;
  endtask

  task automatic test_restart_and_limit_tie();
    set_idling(0, 0);
    write_limit(12'd4);
    send_item(1'b1, 8'hff);
    // header end lands on the limit byte: the end wins, length is missing
    send_crlf();
    send_crlf();
    send_item(1'b0, 8'hff);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h61);
    send_item(1'b0, ChNul);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h62);
    send_item(1'b0, 8'h63);
    write_limit(HeaderLimitReset);
  endtask

  task automatic test_short_request();
    send_item(1'b1, 8'h00);
    send_text("Content-Length: ");
    // CR LF here is skipped as leading blank space
    send_crlf();
    send_item(1'b0, 8'h31);
    send_crlf();
    send_crlf();
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00);
    wait_drained();
  endtask

  task automatic test_header_overrun();
    set_idling(0, 0);
    write_limit(12'd64);
    send_item(1'b1, 8'h00);
    repeat (70) send_item(1'b0, 8'($urandom_range(8'h20, 8'h7e)));
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    write_limit(HeaderLimitReset);
    @(posedge clk);
    hold_left = 400;
    repeat (3) run_request();
    wait_drained();
    set_idling(26, 26);
    repeat (3) begin
      run_request();
      wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned idle_s[4] = '{0, 78, 0, 26};
    int unsigned stall_r[4] = '{0, 0, 78, 26};
    logic [LimitBits-1:0] limits[4];
    int unsigned p;
    int unsigned start;
    limits = '{12'd2048, 12'd4095, 12'($urandom_range(20, 200)), 12'd48};
    for (p = 0; p < 4; p++) begin
      write_limit(limits[p]);
      set_idling(idle_s[p], stall_r[p]);
      start = n_items;
      while (n_items - start < 100) run_request();
      wait_drained();
    end
  endtask

  initial begin
    clear_request();
    limit_m = HeaderLimitReset;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_restart_and_limit_tie();
    test_short_request();
    test_header_overrun();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (6) @(posedge clk);
    $display("Framed %0d requests in %0d items: %0d bodies completed, %0d length errors,",
             n_requests, n_items, n_done, n_len_err);
    $display("%0d header overruns; %0d results checked, %0d mismatches, %0d outstanding",
             n_long_err, n_results, n_mismatch, frame_fifo.size());
    if (n_mismatch == 0 && frame_fifo.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
